// ===== sv/woff2tdp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package woff2tdp_pkg;

    localparam logic [5:0]  HEADER_BYTES = 6'd48;
    localparam logic [5:0]  LITERAL_CODE = 6'd63;
    localparam logic [31:0] VARINT_LIMIT = 32'h01FF_FFFF;
    localparam logic [31:0] SIG_WORD     = 32'h774F_4632;
    localparam logic [31:0] TAG_GLYF     = 32'h676C_7966;
    localparam logic [31:0] TAG_LOCA     = 32'h6C6F_6361;
    localparam logic [31:0] TAG_HMTX     = 32'h686D_7478;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_FLAGS,
        PH_TAG,
        PH_ORIG,
        PH_TRANS,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        KIND_ENTRY = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2
    } result_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_TRUNC    = 3'd1,
        ERR_SIG      = 3'd2,
        ERR_VARINT   = 3'd3,
        ERR_OVERFLOW = 3'd4
    } error_code_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [2:0]  error_code;
        logic [15:0] entry_index;
        logic [31:0] table_tag;
        logic [31:0] table_offset;
        logic [31:0] table_length;
        logic        last_entry;
    } out_item_t;

    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = SIG_WORD[31:24];
            2'd1:    b = SIG_WORD[23:16];
            2'd2:    b = SIG_WORD[15:8];
            default: b = SIG_WORD[7:0];
        endcase
        return b;
    endfunction

    function automatic logic [31:0] known_tag(input logic [5:0] code);
        logic [31:0] t;
        unique case (code)
            6'd0:  t = 32'h636D6170;
            6'd1:  t = 32'h68656164;
            6'd2:  t = 32'h68686561;
            6'd3:  t = 32'h686D7478;
            6'd4:  t = 32'h6D617870;
            6'd5:  t = 32'h6E616D65;
            6'd6:  t = 32'h4F532F32;
            6'd7:  t = 32'h706F7374;
            6'd8:  t = 32'h63767420;
            6'd9:  t = 32'h6670676D;
            6'd10: t = 32'h676C7966;
            6'd11: t = 32'h6C6F6361;
            6'd12: t = 32'h70726570;
            6'd13: t = 32'h43464620;
            6'd14: t = 32'h564F5247;
            6'd15: t = 32'h45424454;
            6'd16: t = 32'h45424C43;
            6'd17: t = 32'h67617370;
            6'd18: t = 32'h68646D78;
            6'd19: t = 32'h6B65726E;
            6'd20: t = 32'h4C545348;
            6'd21: t = 32'h50434C54;
            6'd22: t = 32'h56444D58;
            6'd23: t = 32'h76686561;
            6'd24: t = 32'h766D7478;
            6'd25: t = 32'h42415345;
            6'd26: t = 32'h47444546;
            6'd27: t = 32'h47504F53;
            6'd28: t = 32'h47535542;
            6'd29: t = 32'h45425343;
            6'd30: t = 32'h4A535446;
            6'd31: t = 32'h4D415448;
            6'd32: t = 32'h43424454;
            6'd33: t = 32'h43424C43;
            6'd34: t = 32'h434F4C52;
            6'd35: t = 32'h4350414C;
            6'd36: t = 32'h53564720;
            6'd37: t = 32'h73626978;
            6'd38: t = 32'h61636E74;
            6'd39: t = 32'h61766172;
            6'd40: t = 32'h62646174;
            6'd41: t = 32'h626C6F63;
            6'd42: t = 32'h62736C6E;
            6'd43: t = 32'h63766172;
            6'd44: t = 32'h66647363;
            6'd45: t = 32'h66656174;
            6'd46: t = 32'h666D7478;
            6'd47: t = 32'h66766172;
            6'd48: t = 32'h67766172;
            6'd49: t = 32'h68737479;
            6'd50: t = 32'h6A757374;
            6'd51: t = 32'h6C636172;
            6'd52: t = 32'h6D6F7274;
            6'd53: t = 32'h6D6F7278;
            6'd54: t = 32'h6F706264;
            6'd55: t = 32'h70726F70;
            6'd56: t = 32'h7472616B;
            6'd57: t = 32'h5A617066;
            6'd58: t = 32'h53696C66;
            6'd59: t = 32'h476C6174;
            6'd60: t = 32'h476C6F63;
            6'd61: t = 32'h46656174;
            6'd62: t = 32'h53696C6C;
            default: t = 32'h0;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== sv/woff2tdp_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module woff2tdp_core (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 step,
    input  woff2tdp_pkg::in_item_t    item,
    output logic                      res_valid,
    output woff2tdp_pkg::out_item_t   res
);
    import woff2tdp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [5:0]  hdr_cnt_reg, hdr_cnt_next;
    logic        sig_ok_reg, sig_ok_next;
    logic [15:0] total_reg, total_next;
    logic [15:0] entry_cnt_reg, entry_cnt_next;
    logic [1:0]  tf_ver_reg, tf_ver_next;
    logic [31:0] tag_reg, tag_next;
    logic [1:0]  tag_cnt_reg, tag_cnt_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  vcnt_reg, vcnt_next;
    logic [31:0] offset_reg, offset_next;
    logic        halted_reg, halted_next;

    logic [7:0]  b;
    logic [31:0] acc_sh;
    logic        vbad;
    logic        needs_tf;
    logic [32:0] sum;
    logic [15:0] entry_inc;
    logic [15:0] fail_idx;

    assign b        = item.data_byte;
    assign acc_sh   = {acc_reg[24:0], b[6:0]};
    assign vbad     = ((acc_reg == 32'd0) && (b == 8'h80))
                   || ((vcnt_reg >= 3'd4) && (b[7] || (acc_reg > VARINT_LIMIT)));
    assign needs_tf = ((tf_ver_reg == 2'd0) && ((tag_reg == TAG_GLYF) || (tag_reg == TAG_LOCA)))
                   || ((tf_ver_reg == 2'd1) && (tag_reg == TAG_HMTX));
    assign sum      = {1'b0, offset_reg} + {1'b0, acc_sh};
    assign entry_inc = entry_cnt_reg + 16'd1;
    assign fail_idx = (phase_reg == PH_HEADER) ? 16'd0 : entry_cnt_reg;

    always_comb begin
        phase_next     = phase_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        sig_ok_next    = sig_ok_reg;
        total_next     = total_reg;
        entry_cnt_next = entry_cnt_reg;
        tf_ver_next    = tf_ver_reg;
        tag_next       = tag_reg;
        tag_cnt_next   = tag_cnt_reg;
        acc_next       = acc_reg;
        vcnt_next      = vcnt_reg;
        offset_next    = offset_reg;
        halted_next    = halted_reg;
        res_valid      = 1'b0;
        res            = '0;

        if (step && !halted_reg && (phase_reg != PH_DONE)) begin
            if (item.stream_end) begin
                halted_next     = 1'b1;
                res_valid       = 1'b1;
                res.result_kind = KIND_ERROR;
                res.error_code  = ERR_TRUNC;
                res.entry_index = fail_idx;
            end else begin
                unique case (phase_reg)
                    PH_HEADER: begin
                        if (hdr_cnt_reg < 6'd4) begin
                            if (b != sig_byte(hdr_cnt_reg[1:0])) sig_ok_next = 1'b0;
                        end else if (hdr_cnt_reg == 6'd12) begin
                            total_next = {b, total_reg[7:0]};
                        end else if (hdr_cnt_reg == 6'd13) begin
                            total_next = {total_reg[15:8], b};
                        end
                        hdr_cnt_next = hdr_cnt_reg + 6'd1;
                        if (hdr_cnt_next == HEADER_BYTES) begin
                            if (!sig_ok_next) begin
                                halted_next     = 1'b1;
                                res_valid       = 1'b1;
                                res.result_kind = KIND_ERROR;
                                res.error_code  = ERR_SIG;
                            end else if (total_next == 16'd0) begin
                                phase_next      = PH_DONE;
                                res_valid       = 1'b1;
                                res.result_kind = KIND_EMPTY;
                            end else begin
                                phase_next = PH_FLAGS;
                            end
                        end
                    end
                    PH_FLAGS: begin
                        tf_ver_next = b[7:6];
                        acc_next    = '0;
                        vcnt_next   = '0;
                        if (b[5:0] == LITERAL_CODE) begin
                            tag_next     = '0;
                            tag_cnt_next = '0;
                            phase_next   = PH_TAG;
                        end else begin
                            tag_next   = known_tag(b[5:0]);
                            phase_next = PH_ORIG;
                        end
                    end
                    PH_TAG: begin
                        tag_next     = {tag_reg[23:0], b};
                        tag_cnt_next = tag_cnt_reg + 2'd1;
                        if (tag_cnt_reg == 2'd3) phase_next = PH_ORIG;
                    end
                    PH_ORIG, PH_TRANS: begin
                        if (vbad) begin
                            halted_next     = 1'b1;
                            res_valid       = 1'b1;
                            res.result_kind = KIND_ERROR;
                            res.error_code  = ERR_VARINT;
                            res.entry_index = fail_idx;
                        end else if (b[7]) begin
                            acc_next  = acc_sh;
                            vcnt_next = vcnt_reg + 3'd1;
                        end else begin
                            acc_next  = '0;
                            vcnt_next = '0;
                            if ((phase_reg == PH_ORIG) && needs_tf) begin
                                phase_next = PH_TRANS;
                            end else if (sum[32]) begin
                                halted_next     = 1'b1;
                                res_valid       = 1'b1;
                                res.result_kind = KIND_ERROR;
                                res.error_code  = ERR_OVERFLOW;
                                res.entry_index = entry_cnt_reg;
                            end else begin
                                offset_next      = sum[31:0];
                                entry_cnt_next   = entry_inc;
                                phase_next       = (entry_inc == total_reg) ? PH_DONE : PH_FLAGS;
                                res_valid        = 1'b1;
                                res.result_kind  = KIND_ENTRY;
                                res.error_code   = ERR_NONE;
                                res.entry_index  = entry_cnt_reg;
                                res.table_tag    = tag_reg;
                                res.table_offset = offset_reg;
                                res.table_length = acc_sh;
                                res.last_entry   = (entry_inc == total_reg);
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            hdr_cnt_reg   <= '0;
            sig_ok_reg    <= 1'b1;
            total_reg     <= '0;
            entry_cnt_reg <= '0;
            tf_ver_reg    <= '0;
            tag_reg       <= '0;
            tag_cnt_reg   <= '0;
            acc_reg       <= '0;
            vcnt_reg      <= '0;
            offset_reg    <= '0;
            halted_reg    <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            sig_ok_reg    <= sig_ok_next;
            total_reg     <= total_next;
            entry_cnt_reg <= entry_cnt_next;
            tf_ver_reg    <= tf_ver_next;
            tag_reg       <= tag_next;
            tag_cnt_reg   <= tag_cnt_next;
            acc_reg       <= acc_next;
            vcnt_reg      <= vcnt_next;
            offset_reg    <= offset_next;
            halted_reg    <= halted_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/woff2_table_directory_parser_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Ports                      Word
// input    s_valid s_ready s_data     in_item_t  (data_byte, stream_end)
// result   m_valid m_ready m_data     out_item_t (kind, error, index, tag, offset, length, last)
//
// One byte per cycle sustained while m_ready stays high; each word passes an input register,
// then the parser state update and the result register.
// Bytes that complete no entry produce no result word, unless they raise an error or find an empty directory.
// aresetn is synchronous; it clears both valid flags and all parser state.
// A stalled result register holds the pipe; s_ready drops only when both stages are full.

module woff2_table_directory_parser_top (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  woff2tdp_pkg::in_item_t    s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output woff2tdp_pkg::out_item_t   m_data
);
    import woff2tdp_pkg::*;

    logic      in_vld_reg;
    in_item_t  in_reg;
    logic      out_vld_reg;
    out_item_t out_reg;
    logic      adv;
    logic      res_valid;
    out_item_t res;

    assign adv     = !out_vld_reg || m_ready;
    assign s_ready = !in_vld_reg || adv;
    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    woff2tdp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (in_vld_reg && adv),
        .item      (in_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_ready) in_vld_reg <= s_valid;
            if (adv) out_vld_reg <= in_vld_reg && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) in_reg <= s_data;
        if (adv && in_vld_reg && res_valid) out_reg <= res;
    end

`ifndef SYNTHESIS
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_vld_reg |-> s_ready)
        else $error("input stalled while result register empty");

    a_entry_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.result_kind == KIND_ENTRY)) |-> (m_data.error_code == ERR_NONE))
        else $error("entry word carries an error code");

    a_error_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.result_kind == KIND_ERROR))
        |-> ((m_data.table_tag == 32'd0) && !m_data.last_entry && (m_data.error_code != ERR_NONE)))
        else $error("error word with stray fields");

    a_error_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && (m_data.result_kind == KIND_ERROR)) |=> !m_valid)
        else $error("result word after an error");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_woff2_table_directory_parser_top.sv =====
`timescale 1ns / 1ps

module tb_woff2_table_directory_parser_top;
    import woff2tdp_pkg::*;

    localparam int RUN_LIMIT    = 200000;
    localparam int STALL_CYCLES = 400;

    localparam logic [31:0] TAG_ROM [0:62] = '{
        32'h636D6170, 32'h68656164, 32'h68686561, 32'h686D7478, 32'h6D617870,
        32'h6E616D65, 32'h4F532F32, 32'h706F7374, 32'h63767420, 32'h6670676D,
        32'h676C7966, 32'h6C6F6361, 32'h70726570, 32'h43464620, 32'h564F5247,
        32'h45424454, 32'h45424C43, 32'h67617370, 32'h68646D78, 32'h6B65726E,
        32'h4C545348, 32'h50434C54, 32'h56444D58, 32'h76686561, 32'h766D7478,
        32'h42415345, 32'h47444546, 32'h47504F53, 32'h47535542, 32'h45425343,
        32'h4A535446, 32'h4D415448, 32'h43424454, 32'h43424C43, 32'h434F4C52,
        32'h4350414C, 32'h53564720, 32'h73626978, 32'h61636E74, 32'h61766172,
        32'h62646174, 32'h626C6F63, 32'h62736C6E, 32'h63766172, 32'h66647363,
        32'h66656174, 32'h666D7478, 32'h66766172, 32'h67766172, 32'h68737479,
        32'h6A757374, 32'h6C636172, 32'h6D6F7274, 32'h6D6F7278, 32'h6F706264,
        32'h70726F70, 32'h7472616B, 32'h5A617066, 32'h53696C66, 32'h476C6174,
        32'h476C6F63, 32'h46656174, 32'h53696C6C
    };

    typedef enum int {
        END_LAST,
        END_EMPTY,
        END_SIG,
        END_TRUNC_HDR,
        END_TRUNC_DIR,
        END_VARINT,
        END_OVERFLOW
    } ending_t;

    function automatic bit needs_xform(logic [1:0] ver, logic [31:0] tag);
        return (ver == 2'd0 && (tag == TAG_GLYF || tag == TAG_LOCA)) ||
               (ver == 2'd1 && tag == TAG_HMTX);
    endfunction

    class dir_checker;
        out_item_t   expected_words[$];
        int          mismatches;
        int          words_checked;
        phase_t      stage;
        int          hdr_pos;
        bit          sig_good;
        logic [15:0] dir_size;
        logic [15:0] entries_done;
        logic [1:0]  xver;
        logic [31:0] cur_tag;
        int          tag_bytes;
        logic [31:0] acc;
        int          acc_len;
        logic [31:0] offset_sum;
        bit          stopped;

        function new();
            stage         = PH_HEADER;
            hdr_pos       = 0;
            sig_good      = 1'b1;
            dir_size      = '0;
            entries_done  = '0;
            xver          = '0;
            cur_tag       = '0;
            tag_bytes     = 0;
            acc           = '0;
            acc_len       = 0;
            offset_sum    = '0;
            stopped       = 1'b0;
            mismatches    = 0;
            words_checked = 0;
        endfunction

        function bit raise_error(error_code_t code, output out_item_t r);
            r             = '0;
            r.result_kind = KIND_ERROR;
            r.error_code  = code;
            r.entry_index = (stage == PH_HEADER) ? 16'd0 : entries_done;
            stopped       = 1'b1;
            return 1'b1;
        endfunction

        // -1 bad encoding, 0 more bytes follow, 1 value complete
        function int take_varint(logic [7:0] b);
            if (acc == 32'd0 && b == 8'h80)
                return -1;
            if (acc_len >= 4 && (b[7] || acc > VARINT_LIMIT))
                return -1;
            acc = {acc[24:0], b[6:0]};
            acc_len++;
            return b[7] ? 0 : 1;
        endfunction

        function bit close_entry(logic [31:0] len, output out_item_t r);
            if (len > 32'hFFFF_FFFF - offset_sum)
                return raise_error(ERR_OVERFLOW, r);
            r              = '0;
            r.result_kind  = KIND_ENTRY;
            r.entry_index  = entries_done;
            r.table_tag    = cur_tag;
            r.table_offset = offset_sum;
            r.table_length = len;
            offset_sum     = offset_sum + len;
            entries_done   = entries_done + 16'd1;
            r.last_entry   = (entries_done == dir_size);
            if (r.last_entry)
                stage = PH_DONE;
            else
                stage = PH_FLAGS;
            return 1'b1;
        endfunction

        function bit parse_byte(in_item_t w, output out_item_t r);
            logic [7:0]  b;
            logic [31:0] len;
            int          v;
            b = w.data_byte;
            r = '0;
            if (stopped || stage == PH_DONE)
                return 1'b0;
            if (w.stream_end)
                return raise_error(ERR_TRUNC, r);
            case (stage)
                PH_HEADER: begin
                    if (hdr_pos < 4) begin
                        if (b != SIG_WORD[8*(3-hdr_pos) +: 8])
                            sig_good = 1'b0;
                    end else if (hdr_pos == 12) begin
                        dir_size[15:8] = b;
                    end else if (hdr_pos == 13) begin
                        dir_size[7:0] = b;
                    end
                    hdr_pos++;
                    if (hdr_pos < HEADER_BYTES)
                        return 1'b0;
                    if (!sig_good)
                        return raise_error(ERR_SIG, r);
                    if (dir_size == 16'd0) begin
                        stage         = PH_DONE;
                        r.result_kind = KIND_EMPTY;
                        return 1'b1;
                    end
                    stage = PH_FLAGS;
                    return 1'b0;
                end
                PH_FLAGS: begin
                    xver    = b[7:6];
                    acc     = '0;
                    acc_len = 0;
                    if (b[5:0] == LITERAL_CODE) begin
                        cur_tag   = '0;
                        tag_bytes = 0;
                        stage     = PH_TAG;
                    end else begin
                        cur_tag = TAG_ROM[b[5:0]];
                        stage   = PH_ORIG;
                    end
                    return 1'b0;
                end
                PH_TAG: begin
                    cur_tag = {cur_tag[23:0], b};
                    tag_bytes++;
                    if (tag_bytes == 4)
                        stage = PH_ORIG;
                    return 1'b0;
                end
                PH_ORIG, PH_TRANS: begin
                    v = take_varint(b);
                    if (v < 0)
                        return raise_error(ERR_VARINT, r);
                    if (v == 0)
                        return 1'b0;
                    len     = acc;
                    acc     = '0;
                    acc_len = 0;
                    if (stage == PH_ORIG && needs_xform(xver, cur_tag)) begin
                        stage = PH_TRANS;
                        return 1'b0;
                    end
                    return close_entry(len, r);
                end
                default: return 1'b0;
            endcase
        endfunction

        function void note_byte(in_item_t w);
            out_item_t r;
            if (parse_byte(w, r))
                expected_words.push_back(r);
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void flag_field(string name, logic [31:0] e, logic [31:0] a);
            mismatches++;
            if (mismatches <= 10)
                $display("word %0d %s mismatch: expected %h, got %h",
                         words_checked, name, e, a);
        endfunction

        function void check_word(out_item_t got);
            out_item_t want;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: kind %0d err %0d idx %0d tag %h off %h len %h",
                             got.result_kind, got.error_code, got.entry_index,
                             got.table_tag, got.table_offset, got.table_length);
                return;
            end
            want = expected_words.pop_front();
            words_checked++;
            if (got.result_kind !== want.result_kind)
                flag_field("result_kind", want.result_kind, got.result_kind);
            if (got.error_code !== want.error_code)
                flag_field("error_code", want.error_code, got.error_code);
            if (got.entry_index !== want.entry_index)
                flag_field("entry_index", want.entry_index, got.entry_index);
            if (got.table_tag !== want.table_tag)
                flag_field("table_tag", want.table_tag, got.table_tag);
            if (got.table_offset !== want.table_offset)
                flag_field("table_offset", want.table_offset, got.table_offset);
            if (got.table_length !== want.table_length)
                flag_field("table_length", want.table_length, got.table_length);
            if (got.last_entry !== want.last_entry)
                flag_field("last_entry", want.last_entry, got.last_entry);
        endfunction
    endclass

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    dir_checker      sb;
    in_item_t        stream_q[$];
    longint unsigned gen_offset;
    int              send_idle_pct = 12;
    int              recv_idle_pct = 59;
    int              hold_asks     = 0;
    int              hold_done     = 0;
    int              hold_left     = 0;
    int              cycle_count   = 0;

    woff2_table_directory_parser_top u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: random back-pressure plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                sb.check_word(m_data);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_done != hold_asks) begin
                hold_done = hold_asks;
                hold_left = STALL_CYCLES;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    function automatic void put_byte(logic [7:0] b, bit e = 1'b0);
        in_item_t w;
        w.data_byte  = b;
        w.stream_end = e;
        stream_q.push_back(w);
    endfunction

    function automatic void put_varint(logic [31:0] v);
        int n;
        n = 1;
        while (n < 5 && (v >> (7 * n)) != 0)
            n++;
        for (int i = n - 1; i >= 0; i--)
            put_byte({(i != 0), 7'(v >> (7 * i))});
    endfunction

    // mostly short lengths, a few big ones; never past the 32-bit offset range
    function automatic logic [31:0] pick_length();
        int              sel;
        logic [31:0]     len;
        longint unsigned room;
        sel = $urandom_range(0, 199);
        if (sel < 110)
            len = $urandom_range(0, 127);
        else if (sel < 170)
            len = $urandom_range(128, 16383);
        else if (sel < 194)
            len = $urandom_range(16384, 32'h001F_FFFF);
        else if (sel < 199)
            len = $urandom_range(32'h0020_0000, 32'h0FFF_FFFF);
        else
            len = $urandom();
        room = 64'hFFFF_FFFF - gen_offset;
        if (len > room)
            len = room[31:0];
        return len;
    endfunction

    function automatic void put_entry(logic [7:0] flags, logic [31:0] lit,
                                      logic [31:0] olen, logic [31:0] tlen);
        logic [31:0] tag;
        put_byte(flags);
        if (flags[5:0] == LITERAL_CODE) begin
            tag = lit;
            for (int i = 3; i >= 0; i--)
                put_byte(lit[8*i +: 8]);
        end else begin
            tag = TAG_ROM[flags[5:0]];
        end
        put_varint(olen);
        if (needs_xform(flags[7:6], tag)) begin
            put_varint(tlen);
            gen_offset += tlen;
        end else begin
            gen_offset += olen;
        end
    endfunction

    function automatic void put_random_entry();
        logic [7:0]  flags;
        logic [31:0] lit;
        int          sel;
        flags = 8'($urandom_range(0, 255));
        sel   = $urandom_range(0, 99);
        if (sel < 20) begin
            flags[5:0] = LITERAL_CODE;
        end else if (sel < 40) begin
            // the transformable tables, at version 0 or 1, so that some carry a second length
            case ($urandom_range(0, 2))
                0:       flags[5:0] = 6'd3;
                1:       flags[5:0] = 6'd10;
                default: flags[5:0] = 6'd11;
            endcase
            flags[7:6] = 2'($urandom_range(0, 1));
        end
        lit = $urandom();
        if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 2))
                0:       lit = TAG_GLYF;
                1:       lit = TAG_LOCA;
                default: lit = TAG_HMTX;
            endcase
        end
        put_entry(flags, lit, pick_length(), pick_length());
    endfunction

    function automatic void put_header(bit bad_sig, logic [15:0] count);
        int         bad;
        logic [7:0] b;
        bad = bad_sig ? $urandom_range(0, 3) : -1;
        for (int i = 0; i < 48; i++) begin
            if (i < 4) begin
                b = SIG_WORD[8*(3-i) +: 8];
                if (i == bad)
                    b = b ^ 8'(1 << $urandom_range(0, 7));
            end else if (i == 12) begin
                b = count[15:8];
            end else if (i == 13) begin
                b = count[7:0];
            end else begin
                b = 8'($urandom_range(0, 255));
            end
            put_byte(b);
        end
    endfunction

    function automatic void put_broken_tail(ending_t ending);
        logic [31:0] room;
        logic [31:0] big;
        case (ending)
            END_TRUNC_DIR: begin
                case ($urandom_range(0, 3))
                    0: ;
                    1: begin
                        put_byte({2'($urandom_range(0, 3)), LITERAL_CODE});
                        repeat ($urandom_range(0, 3))
                            put_byte(8'($urandom_range(0, 255)));
                    end
                    2: begin
                        put_byte(8'h05);
                        put_byte(8'($urandom_range(8'h81, 8'hFF)));
                    end
                    default: begin
                        put_byte(8'h0A);
                        put_byte(8'($urandom_range(0, 127)));
                    end
                endcase
                put_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            END_VARINT: begin
                case ($urandom_range(0, 3))
                    0: begin
                        put_byte(8'h01);
                        put_byte(8'h80);
                    end
                    1: begin
                        // leading zero group in the transform length
                        put_byte(8'h0A);
                        put_byte(8'($urandom_range(0, 127)));
                        put_byte(8'h80);
                    end
                    2: begin
                        put_byte(8'h02);
                        put_byte(8'($urandom_range(8'h81, 8'hFF)));
                        repeat (3) put_byte(8'($urandom_range(8'h80, 8'hFF)));
                        put_byte(8'($urandom_range(8'h80, 8'hFF)));
                    end
                    default: begin
                        // value would not fit in 32 bits
                        put_byte(8'h02);
                        put_byte(8'($urandom_range(8'h90, 8'hFF)));
                        repeat (3) put_byte(8'($urandom_range(8'h80, 8'hFF)));
                        put_byte(8'($urandom_range(0, 127)));
                    end
                endcase
            end
            END_OVERFLOW: begin
                room = 32'(64'hFFFF_FFFF - gen_offset);
                big  = $urandom_range(room + 32'd1, 32'hFFFF_FFFF);
                if ($urandom_range(0, 1) == 0)
                    put_entry(8'h0A, 32'd0, 32'($urandom_range(0, 127)), big);
                else
                    put_entry(8'h05, 32'd0, big, 32'd0);
            end
            default: ;
        endcase
    endfunction

    task automatic send_word(input in_item_t w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(w);
    endtask

    initial begin
        ending_t     ending;
        logic [15:0] dir_count;
        int          sel;
        int          n;
        int          n_entries;
        int          directed_end;
        int          stall_at;

        sb         = new();
        gen_offset = 0;

        sel = $urandom_range(0, 99);
        if (sel < 40)      ending = END_LAST;
        else if (sel < 44) ending = END_EMPTY;
        else if (sel < 48) ending = END_SIG;
        else if (sel < 52) ending = END_TRUNC_HDR;
        else if (sel < 68) ending = END_TRUNC_DIR;
        else if (sel < 84) ending = END_VARINT;
        else               ending = END_OVERFLOW;

        if (ending == END_LAST)
            dir_count = 16'($urandom_range(420, 520));
        else if (ending == END_EMPTY)
            dir_count = 16'd0;
        else if ($urandom_range(0, 1) == 0)
            dir_count = 16'hFFFF;
        else
            dir_count = 16'($urandom_range(2000, 65534));

        put_header(ending == END_SIG, dir_count);
        directed_end = stream_q.size();
        if (ending == END_TRUNC_HDR) begin
            n = $urandom_range(0, 47);
            while (stream_q.size() > n)
                void'(stream_q.pop_back());
            put_byte(8'($urandom_range(0, 255)), 1'b1);
            directed_end = stream_q.size();
        end else if (ending != END_SIG && ending != END_EMPTY) begin
            put_entry(8'h0A, 32'd0, 32'd0, 32'h7F);
            put_entry(8'h43, 32'd0, 32'd5, 32'd300);
            put_entry(8'h3F, TAG_GLYF, 32'd1, 32'd2);
            put_entry(8'h4A, 32'd0, 32'h1000_0000, 32'd0);
            put_entry(8'h03, 32'd0, 32'd0, 32'd0);
            put_entry(8'hFF, 32'hFF00_00FF, 32'h7F, 32'd0);
            directed_end = stream_q.size();
            n_entries    = 6;
            if (ending == END_LAST) begin
                while (n_entries < dir_count) begin
                    put_random_entry();
                    n_entries++;
                end
            end else begin
                while (stream_q.size() < 1950)
                    put_random_entry();
                put_broken_tail(ending);
            end
        end
        // trailing bytes must all be dropped
        repeat (16) put_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
        while (stream_q.size() < 1950)
            put_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));

        n        = stream_q.size();
        stall_at = directed_end + (n - directed_end) * 5 / 6;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < n; i++) begin
            if (i < n / 3) begin
                send_idle_pct = 12;
                recv_idle_pct = 59;
            end else if (i < 2 * n / 3) begin
                send_idle_pct = 59;
                recv_idle_pct = 12;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (i == directed_end) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (sb.pending() != 0);
            end
            if (i == stall_at)
                hold_asks++;
            send_word(stream_q[i]);
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Stream of %0d bytes, directory size %0d, ending in %s",
                 n, dir_count, ending.name());
        $display("%0d result words compared, %0d field mismatches",
                 sb.words_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
